/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// ante true at an edge -> cons true at the same edge
`define PTW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// ante true at an edge -> cons true at the next edge
`define PTW_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PTW_ASSERT_IMP(label, clk, rst, ante, cons)
`define PTW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/ptw_pkg.sv */
// Constants, codes and state type for the two-level page table engine.
// No dependencies.
package ptw_pkg;

  localparam int DIR_INDEX_BITS   = 10;
  localparam int TABLE_INDEX_BITS = 10;
  localparam int PAGE_OFFSET_BITS = 12;
  localparam int PS_BITS          = DIR_INDEX_BITS + TABLE_INDEX_BITS;
  localparam int NB               = PS_BITS + 1;   // holds page counts up to the space size
  localparam int FRAME_BITS       = 20;
  localparam int ENTRY_BITS       = FRAME_BITS + 3;

  localparam logic [NB-1:0] PAGE_SPACE = NB'(1) << PS_BITS;

  localparam logic [1:0] ACT_MAP   = 2'd0;
  localparam logic [1:0] ACT_UNMAP = 2'd1;
  localparam logic [1:0] ACT_XLATE = 2'd2;
  localparam logic [1:0] ACT_FIND  = 2'd3;

  typedef enum logic [6:0] {
    S_RCLR    = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_CHECK   = 7'b0000100,
    S_TCLR    = 7'b0001000,
    S_SCAN_RD = 7'b0010000,
    S_SCAN_EV = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic                  user;
    logic                  write;
    logic                  present;
  } entry_t;

endpackage

/* hdl/ptw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptw_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/two_level_page_table_engine_top.sv */
// Two-level page table engine: directory and page RAMs under one sequencer.
// Map/unmap/translate: accept reads both RAMs, CHECK registers the result, DONE loads the output
//   word; a map that creates a directory also clears the new table's 2^TABLE_INDEX_BITS (1024) entries.
// Find free: SCAN_RD/SCAN_EV per present-directory page or absent block; page zero skipped unread.
// One word in flight; a stalled output holds the finished word in the sequencer.
// Reset (sync, high): a clear of all 2^DIR_INDEX_BITS (1024) directory entries, no input taken.
`include "assert_macros.svh"
module two_level_page_table_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] virt_address,
  input  logic [31:0] phys_address,
  input  logic [31:0] end_address,
  input  logic [31:0] byte_count,
  input  logic [1:0]  access_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        success,
  output logic [31:0] address_out,
  output logic        is_mapped,
  output logic        is_writable,
  output logic        is_user
);

  localparam int DIB = ptw_pkg::DIR_INDEX_BITS;
  localparam int TIB = ptw_pkg::TABLE_INDEX_BITS;
  localparam int OFB = ptw_pkg::PAGE_OFFSET_BITS;
  localparam int PSB = ptw_pkg::PS_BITS;
  localparam int NB  = ptw_pkg::NB;
  localparam int EB  = ptw_pkg::ENTRY_BITS;

  ptw_pkg::state_t state, state_next;

  // request context
  logic [1:0]              act;
  logic [PSB-1:0]          page;
  ptw_pkg::entry_t         new_entry;
  logic [OFB-1:0]          offs;
  // sweep counters
  logic [DIB-1:0]          rclr_idx;
  logic [TIB-1:0]          tidx;
  // free-run search
  logic [NB-1:0]           pg, pe, need, run, run_start;
  // result and output words
  logic                    r_success, r_mapped, r_wr, r_user;
  logic [31:0]             r_addr;

  logic in_acc;
  assign in_stall = (state != ptw_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // ---------------- request decode (accept cycle) ----------------
  logic [PSB-1:0] in_page;
  logic [32:0]    pe_raw, need_raw;
  logic [NB-1:0]  ps_cl, pe_cl, need_cl;
  logic [19:0]    ps_raw;

  assign in_page  = virt_address[OFB +: PSB];
  assign ps_raw   = virt_address[31:OFB];
  assign pe_raw   = (33'(end_address) + 33'(12'hFFF)) >> OFB;
  assign need_raw = (33'(byte_count) + 33'(12'hFFF)) >> OFB;

  always_comb begin
    ps_cl = (33'(ps_raw) > 33'(ptw_pkg::PAGE_SPACE)) ? ptw_pkg::PAGE_SPACE : NB'(ps_raw);
    pe_cl = (pe_raw > 33'(ptw_pkg::PAGE_SPACE)) ? ptw_pkg::PAGE_SPACE : NB'(pe_raw);
    if (need_raw == 33'd0) begin
      need_cl = NB'(1);
    end else if (need_raw > 33'(ptw_pkg::PAGE_SPACE)) begin
      need_cl = ptw_pkg::PAGE_SPACE + NB'(1);   // never satisfiable
    end else begin
      need_cl = NB'(need_raw);
    end
  end

  // ---------------- memories ----------------
  logic           dir_we, dir_wdata, dir_re, dir_rdata;
  logic [DIB-1:0] dir_waddr, dir_raddr;
  logic           pg_we, pg_re;
  logic [PSB-1:0] pg_waddr, pg_raddr;
  logic [EB-1:0]  pg_wdata, pg_rdata;
  ptw_pkg::entry_t rd_entry;
  assign rd_entry = ptw_pkg::entry_t'(pg_rdata);

  ptw_ram #(.ADDR_BITS(DIB), .DATA_BITS(1)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .re(dir_re), .raddr(dir_raddr), .rdata(dir_rdata)
  );

  ptw_ram #(.ADDR_BITS(PSB), .DATA_BITS(EB)) u_pages (
    .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
    .re(pg_re), .raddr(pg_raddr), .rdata(pg_rdata)
  );

  // reads: request page on accept, scan page in SCAN_RD
  logic [PSB-1:0] rd_page;
  assign rd_page   = (state == ptw_pkg::S_IDLE) ? in_page : pg[PSB-1:0];
  assign pg_raddr  = rd_page;
  assign dir_raddr = rd_page[PSB-1:TIB];

  // scan step decisions
  logic          scan_found, scan_end, scan_zero;
  logic [DIB:0]  blk_dir;
  logic [NB-1:0] blk_end, blk_cl, run_new;
  assign scan_found = (run >= need);
  assign scan_end   = (pg >= pe);
  assign scan_zero  = (pg == '0);
  assign dir_re     = in_acc || (state == ptw_pkg::S_SCAN_RD && !scan_found && !scan_end
                                 && !scan_zero);
  assign pg_re      = dir_re;

  assign blk_dir = pg[NB-1:TIB] + (DIB+1)'(1);
  assign blk_end = {blk_dir, {TIB{1'b0}}};
  assign blk_cl  = (blk_end > pe) ? pe : blk_end;

  always_comb begin
    if (!dir_rdata) begin
      run_new = run + (blk_cl - pg);
    end else if (rd_entry.present) begin
      run_new = '0;
    end else begin
      run_new = run + NB'(1);
    end
  end

  logic [63:0] found_addr;
  assign found_addr = 64'(run_start) << OFB;

  // writes
  logic map_miss;
  assign map_miss = (state == ptw_pkg::S_CHECK) && (act == ptw_pkg::ACT_MAP) && !dir_rdata;

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = page[PSB-1:TIB];
    dir_wdata = 1'b1;
    pg_we     = 1'b0;
    pg_waddr  = page;
    pg_wdata  = EB'(new_entry);
    if (state == ptw_pkg::S_RCLR) begin
      dir_we    = 1'b1;
      dir_waddr = rclr_idx;
      dir_wdata = 1'b0;
    end else if (map_miss) begin
      dir_we = 1'b1;
    end
    if (state == ptw_pkg::S_CHECK) begin
      unique case (act)
        ptw_pkg::ACT_MAP:   pg_we = dir_rdata;
        ptw_pkg::ACT_UNMAP: begin
          pg_we    = dir_rdata && rd_entry.present;
          pg_wdata = '0;
        end
        default:            pg_we = 1'b0;
      endcase
    end else if (state == ptw_pkg::S_TCLR) begin
      // clear the new table; the mapped slot gets the entry on its way past
      pg_we    = 1'b1;
      pg_waddr = {page[PSB-1:TIB], tidx};
      pg_wdata = (tidx == page[TIB-1:0]) ? EB'(new_entry) : '0;
    end
  end

  // ---------------- sequencer ----------------
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ptw_pkg::S_RCLR:    if (rclr_idx == '1) state_next = ptw_pkg::S_IDLE;
      ptw_pkg::S_IDLE: begin
        if (in_acc) begin
          state_next = (action == ptw_pkg::ACT_FIND) ? ptw_pkg::S_SCAN_RD : ptw_pkg::S_CHECK;
        end
      end
      ptw_pkg::S_CHECK:   state_next = map_miss ? ptw_pkg::S_TCLR : ptw_pkg::S_DONE;
      ptw_pkg::S_TCLR:    if (tidx == '1) state_next = ptw_pkg::S_DONE;
      ptw_pkg::S_SCAN_RD: begin
        priority if (scan_found || scan_end) state_next = ptw_pkg::S_DONE;
        else if (!scan_zero)                 state_next = ptw_pkg::S_SCAN_EV;
        else                                 state_next = ptw_pkg::S_SCAN_RD;
      end
      ptw_pkg::S_SCAN_EV: state_next = ptw_pkg::S_SCAN_RD;
      ptw_pkg::S_DONE:    if (out_free) state_next = ptw_pkg::S_IDLE;
      default:            state_next = ptw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptw_pkg::S_RCLR;
      rclr_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ptw_pkg::S_RCLR) rclr_idx <= rclr_idx + DIB'(1);
      if (state == ptw_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // context, search and result words
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act               <= action;
      page              <= in_page;
      offs              <= virt_address[OFB-1:0];
      new_entry.frame   <= phys_address[31:OFB];
      new_entry.user    <= access_flags[1];
      new_entry.write   <= access_flags[0];
      new_entry.present <= 1'b1;
      pg                <= ps_cl;
      pe                <= pe_cl;
      need              <= need_cl;
      run               <= '0;
      run_start         <= ps_cl;
      tidx              <= '0;
    end
    unique case (state)
      ptw_pkg::S_CHECK: begin
        r_success <= 1'b0;
        r_addr    <= '0;
        r_mapped  <= 1'b0;
        r_wr      <= 1'b0;
        r_user    <= 1'b0;
        unique case (act)
          ptw_pkg::ACT_MAP:   r_success <= 1'b1;
          ptw_pkg::ACT_UNMAP: r_success <= dir_rdata && rd_entry.present;
          default: begin
            if (dir_rdata) begin
              r_success <= 1'b1;
              r_addr    <= {rd_entry.frame, offs};
              r_mapped  <= rd_entry.present;
              r_wr      <= rd_entry.present && rd_entry.write;
              r_user    <= rd_entry.present && rd_entry.user;
            end
          end
        endcase
      end
      ptw_pkg::S_TCLR: tidx <= tidx + TIB'(1);
      ptw_pkg::S_SCAN_RD: begin
        r_success <= scan_found;
        r_addr    <= scan_found ? found_addr[31:0] : 32'd0;
        r_mapped  <= 1'b0;
        r_wr      <= 1'b0;
        r_user    <= 1'b0;
        if (!scan_found && !scan_end && scan_zero) begin
          // page zero is reserved
          run       <= '0;
          run_start <= NB'(1);
          pg        <= NB'(1);
        end
      end
      ptw_pkg::S_SCAN_EV: begin
        run <= run_new;
        if (dir_rdata && rd_entry.present) run_start <= pg + NB'(1);
        pg <= dir_rdata ? pg + NB'(1) : blk_cl;
      end
      default: ;
    endcase
    if (state == ptw_pkg::S_DONE && out_free) begin
      success     <= r_success;
      address_out <= r_addr;
      is_mapped   <= r_mapped;
      is_writable <= r_wr;
      is_user     <= r_user;
    end
  end

  // ---------------- assertions ----------------
  `PTW_ASSERT_IMP(a_no_out_in_clear, clk, rst, state == ptw_pkg::S_RCLR, !out_valid)
  `PTW_ASSERT_IMP(a_pg_in_space, clk, rst, state == ptw_pkg::S_SCAN_EV, pg < ptw_pkg::PAGE_SPACE)
  `PTW_ASSERT_IMP(a_run_bounded, clk, rst, state == ptw_pkg::S_SCAN_RD, run <= ptw_pkg::PAGE_SPACE)
  `PTW_ASSERT_NXT(a_tclr_after_miss, clk, rst, map_miss, state == ptw_pkg::S_TCLR)

endmodule
